// ===== rtl/core/dfir_pkg.sv =====
`timescale 1ns / 1ps

package dfir_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 24;
  localparam int OUT_W      = 24;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS  = 23;
  localparam int COEF_IDX_W = 8;
  localparam int TAP_CNT_W  = 9;
  localparam int DEC_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 2'd1;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET  = 9'd256;
  localparam logic [DEC_W-1:0]     DECIMATION_RESET = 7'd1;

  localparam logic [OUT_W-1:0] OUT_MAX = 24'h7F_FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 24'h80_0000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NORM,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic coef_wr;
    logic sample_load;
    logic norm_start;
    logic norm_step;
    logic ring_write;
    logic mac_issue;
    logic round_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic pos_stale;
    logic norm_last;
    logic fire;
    logic issue_last;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/dfir_ram.sv =====
`timescale 1ns / 1ps

module dfir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/dfir_ctrl.sv =====
`timescale 1ns / 1ps

module dfir_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             opcode,
  output logic             item_stall,
  output dfir_pkg::cmd_t    cmd,
  input  dfir_pkg::status_t status
);

  dfir_pkg::state_t state;
  dfir_pkg::state_t state_next;
  logic             take;

  assign take       = item_valid && (state == dfir_pkg::ST_IDLE);
  assign item_stall = (state != dfir_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfir_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dfir_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = dfir_pkg::ST_IDLE;
      end
      dfir_pkg::ST_IDLE: begin
        if (take && (opcode == dfir_pkg::OP_SAMPLE)) begin
          state_next = status.pos_stale ? dfir_pkg::ST_NORM : dfir_pkg::ST_WRITE;
        end
      end
      dfir_pkg::ST_NORM: begin
        if (status.norm_last) state_next = dfir_pkg::ST_WRITE;
      end
      dfir_pkg::ST_WRITE: begin
        state_next = status.fire ? dfir_pkg::ST_MAC : dfir_pkg::ST_IDLE;
      end
      dfir_pkg::ST_MAC: begin
        if (status.issue_last) state_next = dfir_pkg::ST_DRAIN;
      end
      dfir_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) state_next = dfir_pkg::ST_ROUND;
      end
      dfir_pkg::ST_ROUND: begin
        state_next = dfir_pkg::ST_OUTPUT;
      end
      dfir_pkg::ST_OUTPUT: begin
        if (status.out_free) state_next = dfir_pkg::ST_IDLE;
      end
      default: state_next = dfir_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      dfir_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      dfir_pkg::ST_IDLE: begin
        cmd.coef_wr     = take && (opcode == dfir_pkg::OP_COEF);
        cmd.sample_load = take && (opcode == dfir_pkg::OP_SAMPLE);
        cmd.norm_start  = take && (opcode == dfir_pkg::OP_SAMPLE);
      end
      dfir_pkg::ST_NORM: begin
        cmd.norm_step = 1'b1;
      end
      dfir_pkg::ST_WRITE: begin
        cmd.ring_write = 1'b1;
      end
      dfir_pkg::ST_MAC: begin
        cmd.mac_issue = 1'b1;
      end
      dfir_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      dfir_pkg::ST_ROUND: begin
        cmd.round_load = 1'b1;
      end
      dfir_pkg::ST_OUTPUT: begin
        cmd.out_load = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/dfir_datapath.sv =====
`timescale 1ns / 1ps

module dfir_datapath #(
  parameter int MAX_TAPS       = 256,
  parameter int MAX_DECIMATION = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dfir_pkg::cmd_t                        cmd,
  output dfir_pkg::status_t                     status,
  input  logic                                  cfg_wr,
  input  logic [dfir_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dfir_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [dfir_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic [dfir_pkg::COEF_IDX_W-1:0]       coef_index,
  input  logic signed [dfir_pkg::COEF_W-1:0]    coef_value,
  input  logic                                  result_stall,
  output logic                                  result_valid,
  output logic signed [dfir_pkg::OUT_W-1:0]     filtered_sample
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int TW    = $clog2(MAX_TAPS + 1);
  localparam int SW    = (AW > 1) ? $clog2(AW) : 1;
  localparam int PH_W  = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
  localparam int ACC_W = dfir_pkg::PROD_W + $clog2(MAX_TAPS);
  localparam int QW    = ACC_W + 1 - dfir_pkg::FRAC_BITS;
  localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W + 1)'(1) << (dfir_pkg::FRAC_BITS - 1);

  // Configuration registers keep the written bits; clamping happens on use.
  logic [dfir_pkg::TAP_CNT_W-1:0] tap_count;
  logic [dfir_pkg::DEC_W-1:0]     decimation_factor;

  logic [AW-1:0]   pos;
  logic [PH_W-1:0] phase;
  logic [AW-1:0]   clear_cnt;
  logic [SW-1:0]   step;
  logic [AW-1:0]   tap_j;
  logic [AW-1:0]   ring_k;
  logic [dfir_pkg::SAMPLE_W-1:0] sample_reg;

  logic [31:0]   taps32;
  logic [31:0]   factor32;
  logic [31:0]   phase_inc;
  logic [TW-1:0] taps;
  logic [TW-1:0] pos_inc;
  logic [AW-1:0] pos_next;
  logic [TW-1:0] k_inc;
  logic [AW+TW-1:0] taps_shift;
  logic [AW+TW-1:0] pos_wide;
  logic          fire;
  logic          coef_idx_ok;

  logic                          coef_we;
  logic [AW-1:0]                 coef_waddr;
  logic [dfir_pkg::COEF_W-1:0]   coef_wdata;
  logic [dfir_pkg::COEF_W-1:0]   coef_rd;
  logic                          samp_we;
  logic [AW-1:0]                 samp_waddr;
  logic [dfir_pkg::SAMPLE_W-1:0] samp_wdata;
  logic [dfir_pkg::SAMPLE_W-1:0] samp_rd;

  logic                              rd_valid;
  logic                              prod_valid;
  logic signed [dfir_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]           acc;
  logic signed [ACC_W:0]             acc_rnd;
  logic signed [QW-1:0]              quot;
  logic [QW-dfir_pkg::OUT_W:0]       quot_hi;
  logic [dfir_pkg::OUT_W-1:0]        sat_val;
  logic [dfir_pkg::OUT_W-1:0]        round_reg;

  always_comb begin
    if (tap_count == '0) begin
      taps32 = 32'd1;
    end else if (32'(tap_count) > MAX_TAPS) begin
      taps32 = 32'(MAX_TAPS);
    end else begin
      taps32 = 32'(tap_count);
    end
    if (decimation_factor == '0) begin
      factor32 = 32'd1;
    end else if (32'(decimation_factor) > MAX_DECIMATION) begin
      factor32 = 32'(MAX_DECIMATION);
    end else begin
      factor32 = 32'(decimation_factor);
    end
  end

  assign taps       = TW'(taps32);
  assign pos_inc    = TW'(pos) + TW'(1);
  assign pos_next   = (pos_inc >= taps) ? '0 : AW'(pos_inc);
  assign k_inc      = TW'(ring_k) + TW'(1);
  assign phase_inc  = 32'(phase) + 32'd1;
  assign fire       = (phase_inc >= factor32);
  assign taps_shift = (AW + TW)'(taps) << step;
  assign pos_wide   = (AW + TW)'(pos);
  assign coef_idx_ok = (32'(coef_index) < MAX_TAPS);

  assign status.clear_last = (clear_cnt == AW'(MAX_TAPS - 1));
  assign status.pos_stale  = (TW'(pos) >= taps);
  assign status.norm_last  = (step == '0);
  assign status.fire       = fire;
  assign status.issue_last = (TW'(tap_j) == (taps - TW'(1)));
  assign status.pipe_busy  = rd_valid | prod_valid;
  assign status.out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count         <= dfir_pkg::TAP_COUNT_RESET;
      decimation_factor <= dfir_pkg::DECIMATION_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        dfir_pkg::CFG_TAP_COUNT:  tap_count <= cfg_data[dfir_pkg::TAP_CNT_W-1:0];
        dfir_pkg::CFG_DECIMATION: decimation_factor <= cfg_data[dfir_pkg::DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Position reduction after a tap-count change is a restoring remainder,
  // one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      phase     <= '0;
      clear_cnt <= '0;
      step      <= '0;
    end else begin
      if (cmd.clear_wr) begin
        clear_cnt <= clear_cnt + AW'(1);
      end
      if (cmd.norm_start) begin
        step <= SW'(AW - 1);
      end
      if (cmd.norm_step) begin
        if (pos_wide >= taps_shift) begin
          pos <= AW'(pos_wide - taps_shift);
        end
        step <= step - SW'(1);
      end
      if (cmd.ring_write) begin
        pos   <= pos_next;
        phase <= fire ? '0 : PH_W'(phase_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_load) begin
      sample_reg <= sample_value;
    end
    if (cmd.ring_write) begin
      tap_j  <= '0;
      ring_k <= pos_next;
    end else if (cmd.mac_issue) begin
      tap_j  <= tap_j + AW'(1);
      ring_k <= (k_inc >= taps) ? '0 : AW'(k_inc);
    end
  end

  assign coef_we    = cmd.clear_wr || (cmd.coef_wr && coef_idx_ok);
  assign coef_waddr = cmd.clear_wr ? clear_cnt : AW'(coef_index);
  assign coef_wdata = cmd.clear_wr ? '0 : coef_value;
  assign samp_we    = cmd.clear_wr || cmd.ring_write;
  assign samp_waddr = cmd.clear_wr ? clear_cnt : pos;
  assign samp_wdata = cmd.clear_wr ? '0 : sample_reg;

  dfir_ram #(
    .WIDTH (dfir_pkg::COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk     (clk),
    .we      (coef_we),
    .wr_addr (coef_waddr),
    .wr_data (coef_wdata),
    .rd_addr (tap_j),
    .rd_data (coef_rd)
  );

  dfir_ram #(
    .WIDTH (dfir_pkg::SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_sample_ram (
    .clk     (clk),
    .we      (samp_we),
    .wr_addr (samp_waddr),
    .wr_data (samp_wdata),
    .rd_addr (ring_k),
    .rd_data (samp_rd)
  );

  // Read, multiply and accumulate each take one stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.mac_issue;
      prod_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(coef_rd) * $signed(samp_rd);
    if (cmd.ring_write) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up, then floor-shift; saturate when the upper bits are not
  // all copies of the output sign bit.
  assign acc_rnd = (ACC_W + 1)'(acc) + RND_BIAS;
  assign quot    = QW'(acc_rnd >>> dfir_pkg::FRAC_BITS);
  assign quot_hi = quot[QW-1:dfir_pkg::OUT_W-1];

  always_comb begin
    if ((&quot_hi) || !(|quot_hi)) begin
      sat_val = quot[dfir_pkg::OUT_W-1:0];
    end else if (quot[QW-1]) begin
      sat_val = dfir_pkg::OUT_MIN;
    end else begin
      sat_val = dfir_pkg::OUT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_load) begin
      round_reg <= sat_val;
    end
    if (cmd.out_load) begin
      filtered_sample <= round_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/decimating_fir_filter.sv =====
`timescale 1ns / 1ps
// A coefficient write is taken without holding the input. A sample without
// output passes through the ring write and returns to idle; a sample with
// output then runs the taps in use, one tap per cycle through a single
// multiply-accumulate unit, drains, rounds and waits out any stall on the result
// port. Either sample first reduces the write position after a tap-count change.
// Synchronous reset; both stores are then zeroed in a pass that accepts no request, only configuration writes.
module decimating_fir_filter #(
  parameter int MAX_TAPS       = 256,
  parameter int MAX_DECIMATION = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  opcode,
  input  logic signed [dfir_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic [dfir_pkg::COEF_IDX_W-1:0]       coef_index,
  input  logic signed [dfir_pkg::COEF_W-1:0]    coef_value,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [dfir_pkg::OUT_W-1:0]     filtered_sample,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dfir_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dfir_pkg::CFG_DATA_W-1:0]       cfg_data
);

  dfir_pkg::cmd_t    cmd;
  dfir_pkg::status_t status;

  assign cfg_ready = 1'b1;

  dfir_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .opcode     (opcode),
    .item_stall (item_stall),
    .cmd        (cmd),
    .status     (status)
  );

  dfir_datapath #(
    .MAX_TAPS       (MAX_TAPS),
    .MAX_DECIMATION (MAX_DECIMATION)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_value    (sample_value),
    .coef_index      (coef_index),
    .coef_value      (coef_value),
    .result_stall    (result_stall),
    .result_valid    (result_valid),
    .filtered_sample (filtered_sample)
  );

endmodule

// ===== rtl/core/dfir_checker.sv =====
`timescale 1ns / 1ps

module dfir_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_valid,
  input logic                              item_stall,
  input logic                              opcode,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [dfir_pkg::OUT_W-1:0]        filtered_sample
);

  // A stalled result keeps its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(filtered_sample))
    else $error("stalled result changed");

  // The store clearing pass after reset holds off requests.
  assert property (@(posedge clk) rst |=> item_stall)
    else $error("request accepted during clearing pass");

  // A sample request is always followed by a busy period.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (opcode == dfir_pkg::OP_SAMPLE) |=> item_stall)
    else $error("sample request not followed by busy cycle");

  // A coefficient write leaves the input free in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (opcode == dfir_pkg::OP_COEF) |=> !item_stall)
    else $error("coefficient write held the input");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without computation");

endmodule

bind decimating_fir_filter dfir_checker u_dfir_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item_valid),
  .item_stall      (item_stall),
  .opcode          (opcode),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .filtered_sample (filtered_sample)
);
